// ----- design/rtm_pkg.sv -----
// Shared types and constants for the response token matcher.
// No dependencies; imported by response_token_matcher_top.
package rtm_pkg;

	localparam int unsigned TOKEN_W = 64;
	localparam int unsigned LEN_W   = 4;
	localparam int unsigned POS_W   = 16;
	localparam int unsigned TICK_W  = 32;

	typedef enum logic [1:0] {
		CMD_BYTE  = 2'd0,
		CMD_TICK  = 2'd1,
		CMD_START = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_STORED   = 2'd0,
		ST_FOUND    = 2'd1,
		ST_OVERFLOW = 2'd2,
		ST_TIMEOUT  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		REG_TOKEN_BYTES   = 2'd0,
		REG_TOKEN_LENGTH  = 2'd1,
		REG_OUT_CAPACITY  = 2'd2,
		REG_TIMEOUT_TICKS = 2'd3
	} reg_idx_t;

	localparam logic [7:0] NUL_BYTE = 8'h00;

	// byte i of the token, index taken modulo 8
	function automatic logic [7:0] token_at(input logic [TOKEN_W-1:0] tok,
		input logic [2:0] idx);
		return tok[{idx, 3'b000} +: 8];
	endfunction

endpackage

// ----- design/response_token_matcher_top.sv -----
// Response token matcher: scans received bytes for a terminator token,
// tracks buffer position and a tick timeout. Depends on rtm_pkg.
//
// channel   dir   handshake            payload
// in        in    in_valid/in_ready    command, data_byte
// out       out   out_valid/out_ready  status, stored_byte, position, finished
// cfg       in    cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One item per cycle while the output is not stalled. An accepted item sits in
// the input register, is evaluated against the search state, and its result
// (if any) lands in the output register when the output side advances.
// The input stage advances whenever the output register is empty or being
// taken, so out_ready low with a result held stalls in_ready. Reset puts the
// block idle with the register defaults; no clearing pass. cfg_ready is always high.
module response_token_matcher_top #(
	parameter int unsigned MAX_TOKEN = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    command,
	input  logic [7:0]                    data_byte,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [1:0]                    status,
	output logic [7:0]                    stored_byte,
	output logic [rtm_pkg::POS_W-1:0]     position,
	output logic                          finished,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [1:0]                    cfg_index,
	input  logic [rtm_pkg::TOKEN_W-1:0]   cfg_data
);
	import rtm_pkg::*;

	localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_TOKEN);

	// configuration registers
	logic [TOKEN_W-1:0] token_bytes_q;
	logic [LEN_W-1:0]   token_length_q;
	logic [POS_W-1:0]   out_capacity_q;
	logic [TICK_W-1:0]  timeout_ticks_q;

	// search state
	logic               searching_q;
	logic [POS_W-1:0]   byte_count_q;
	logic [LEN_W-1:0]   match_index_q;
	logic [TICK_W-1:0]  elapsed_q;

	// input stage
	logic               valid_s1;
	cmd_t               cmd_s1;
	logic [7:0]         byte_s1;

	// evaluation
	logic               advance;
	logic               res_emit;
	status_t            res_status;
	logic [7:0]         res_byte;
	logic [POS_W-1:0]   res_pos;
	logic               res_fin;
	logic               nxt_searching;
	logic [POS_W-1:0]   nxt_byte_count;
	logic [LEN_W-1:0]   nxt_match;
	logic [TICK_W-1:0]  nxt_elapsed;
	logic [LEN_W-1:0]   eff_len;
	logic [LEN_W-1:0]   cur_match;
	logic [LEN_W-1:0]   new_match;
	logic [TICK_W-1:0]  elapsed_inc;

	assign cfg_ready = 1'b1;
	assign advance   = !out_valid || out_ready;
	assign in_ready  = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			token_bytes_q   <= TOKEN_W'(2573);
			token_length_q  <= LEN_W'(2);
			out_capacity_q  <= POS_W'(64);
			timeout_ticks_q <= TICK_W'(1000);
		end else if (cfg_valid && cfg_ready) begin
			case (reg_idx_t'(cfg_index))
				REG_TOKEN_BYTES:   token_bytes_q   <= cfg_data;
				REG_TOKEN_LENGTH:  token_length_q  <= cfg_data[LEN_W-1:0];
				REG_OUT_CAPACITY:  out_capacity_q  <= cfg_data[POS_W-1:0];
				REG_TIMEOUT_TICKS: timeout_ticks_q <= cfg_data[TICK_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			cmd_s1  <= cmd_t'(command);
			byte_s1 <= data_byte;
		end
	end

	always_comb begin
		eff_len = token_length_q;
		if (eff_len == '0)
			eff_len = LEN_W'(1);
		if (eff_len > MAX_LEN)
			eff_len = MAX_LEN;
	end

	// naive match: on a miss, retry the same byte against token byte 0
	assign cur_match = (match_index_q >= eff_len) ? '0 : match_index_q;
	always_comb begin
		if (byte_s1 == token_at(token_bytes_q, cur_match[2:0]))
			new_match = cur_match + LEN_W'(1);
		else if (byte_s1 == token_at(token_bytes_q, 3'd0))
			new_match = LEN_W'(1);
		else
			new_match = '0;
	end

	assign elapsed_inc = elapsed_q + TICK_W'(1);

	always_comb begin
		res_emit       = 1'b0;
		res_status     = ST_STORED;
		res_byte       = NUL_BYTE;
		res_pos        = byte_count_q;
		res_fin        = 1'b0;
		nxt_searching  = searching_q;
		nxt_byte_count = byte_count_q;
		nxt_match      = match_index_q;
		nxt_elapsed    = elapsed_q;
		case (cmd_s1)
			CMD_START: begin
				nxt_byte_count = '0;
				nxt_match      = '0;
				nxt_elapsed    = '0;
				nxt_searching  = 1'b1;
				if (timeout_ticks_q == '0) begin
					nxt_searching = 1'b0;
					res_emit      = 1'b1;
					res_status    = ST_TIMEOUT;
					res_pos       = '0;
					res_fin       = 1'b1;
				end
			end
			CMD_TICK: begin
				if (searching_q) begin
					nxt_elapsed = elapsed_inc;
					if (elapsed_inc >= timeout_ticks_q) begin
						nxt_searching = 1'b0;
						res_emit      = 1'b1;
						res_status    = ST_TIMEOUT;
						res_fin       = 1'b1;
					end
				end
			end
			CMD_BYTE: begin
				if (searching_q) begin
					res_emit = 1'b1;
					if (byte_count_q >= out_capacity_q) begin
						nxt_searching = 1'b0;
						res_status    = ST_OVERFLOW;
						res_fin       = 1'b1;
					end else begin
						nxt_match = new_match;
						res_byte  = byte_s1;
						if (new_match >= eff_len) begin
							nxt_searching = 1'b0;
							res_status    = ST_FOUND;
							res_fin       = 1'b1;
						end else begin
							nxt_byte_count = byte_count_q + POS_W'(1);
						end
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			searching_q   <= 1'b0;
			byte_count_q  <= '0;
			match_index_q <= '0;
			elapsed_q     <= '0;
		end else if (valid_s1 && advance) begin
			searching_q   <= nxt_searching;
			byte_count_q  <= nxt_byte_count;
			match_index_q <= nxt_match;
			elapsed_q     <= nxt_elapsed;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= valid_s1 && res_emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && res_emit) begin
			status      <= res_status;
			stored_byte <= res_byte;
			position    <= res_pos;
			finished    <= res_fin;
		end
	end

	a_fin_stops: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && advance && res_emit && res_fin) |=> !searching_q)
		else $error("search still running after a finishing result");

	a_store_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && advance && res_emit && res_status == ST_STORED)
		|=> byte_count_q == $past(byte_count_q) + POS_W'(1))
		else $error("stored byte did not advance the position");

	a_match_bound: assert property (@(posedge clk) disable iff (!arst_n)
		match_index_q <= MAX_LEN)
		else $error("match index beyond the longest token");

endmodule

// ----- sim/tb_top.sv -----
// Testbench for response_token_matcher_top: directed and random searches of byte, tick
// and start items, each result checked against a built-in model of the token search.
// Depends on rtm_pkg and the design files.
`timescale 1ns / 100ps

module tb_top;
	import rtm_pkg::*;

	localparam int unsigned TOKEN_MAX   = 8;
	localparam int          ITEM_GOAL   = 1300;
	localparam int          PIPE_SLACK  = 8;
	localparam int          HOLD_CYCLES = 300;
	localparam int          CYCLE_LIMIT = 400000;

	typedef struct packed {
		cmd_t       cmd;
		logic [7:0] b;
	} link_item_t;

	typedef struct packed {
		status_t     st;
		logic [7:0]  b;
		logic [15:0] pos;
		logic        fin;
	} scan_report_t;

	logic                clk         = 1'b0;
	logic                arst_n      = 1'b0;
	logic                in_valid    = 1'b0;
	logic                in_ready;
	logic [1:0]          command     = CMD_NONE;
	logic [7:0]          data_byte   = 8'h00;
	logic                out_valid;
	logic                out_ready   = 1'b0;
	logic [1:0]          status;
	logic [7:0]          stored_byte;
	logic [POS_W-1:0]    position;
	logic                finished;
	logic                cfg_valid   = 1'b0;
	logic                cfg_ready;
	logic [1:0]          cfg_index   = REG_TOKEN_BYTES;
	logic [TOKEN_W-1:0]  cfg_data    = '0;

	// model copy of the registers (reset values) and of the search state
	logic [TOKEN_W-1:0]  tok_bytes   = 64'h0A0D;
	logic [LEN_W-1:0]    tok_len     = 4'd2;
	logic [POS_W-1:0]    buf_cap     = 16'd64;
	logic [TICK_W-1:0]   tick_limit  = 32'd1000;
	logic                searching   = 1'b0;
	logic [POS_W-1:0]    byte_cnt    = '0;
	logic [LEN_W-1:0]    match_idx   = '0;
	logic [TICK_W-1:0]   elapsed     = '0;

	link_item_t   stim[$];
	scan_report_t scan_reports[$];

	logic in_taken  = 1'b0;
	logic out_taken = 1'b0;
	logic rx_hold   = 1'b0;
	int   tx_pace   = 1;
	int   rx_pace   = 1;
	int   tx_wait   = 0;
	int   rx_wait   = 0;
	int   errors    = 0;
	int   items_offered = 0;
	int   cycle_count   = 0;

	response_token_matcher_top #(.MAX_TOKEN(TOKEN_MAX)) DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.command     (command),
		.data_byte   (data_byte),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.stored_byte (stored_byte),
		.position    (position),
		.finished    (finished),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic int draw_wait(input int pace);
		case (pace)
			0:       return 0;
			1:       return $urandom_range(0, 19);
			default: return ($urandom_range(0, 7) == 0) ? $urandom_range(0, 19) : 0;
		endcase
	endfunction

	function automatic logic [3:0] active_len();
		if (tok_len == 4'd0) return 4'd1;
		if (tok_len > TOKEN_MAX) return 4'(TOKEN_MAX);
		return tok_len;
	endfunction

	function automatic logic [7:0] tok_byte(input int i);
		return tok_bytes[8*(i%8) +: 8];
	endfunction

	function automatic scan_report_t mk_report(input status_t st, input logic [7:0] b,
		input logic [15:0] pos, input logic fin);
		scan_report_t r;
		r.st  = st;
		r.b   = b;
		r.pos = pos;
		r.fin = fin;
		return r;
	endfunction

	// one item through the search; returns 1 when it yields a result
	function automatic bit scan_step(input cmd_t cmd, input logic [7:0] b,
		output scan_report_t r);
		logic [3:0] len;
		len = active_len();
		r = mk_report(ST_STORED, 8'h00, 16'h0000, 1'b0);
		if (cmd == CMD_START) begin
			byte_cnt  = '0;
			match_idx = '0;
			elapsed   = '0;
			searching = 1'b1;
			if (tick_limit == 0) begin
				searching = 1'b0;
				r = mk_report(ST_TIMEOUT, 8'h00, 16'h0000, 1'b1);
				return 1'b1;
			end
			return 1'b0;
		end
		if (!searching || cmd == CMD_NONE) return 1'b0;
		if (cmd == CMD_TICK) begin
			elapsed++;
			if (elapsed >= tick_limit) begin
				searching = 1'b0;
				r = mk_report(ST_TIMEOUT, 8'h00, byte_cnt, 1'b1);
				return 1'b1;
			end
			return 1'b0;
		end
		// full buffer wins over a match
		if (byte_cnt >= buf_cap) begin
			searching = 1'b0;
			r = mk_report(ST_OVERFLOW, 8'h00, byte_cnt, 1'b1);
			return 1'b1;
		end
		if (match_idx >= len) match_idx = '0;
		if (b == tok_byte(match_idx))
			match_idx++;
		else
			match_idx = (b == tok_byte(0)) ? 4'd1 : 4'd0;
		if (match_idx >= len) begin
			searching = 1'b0;
			r = mk_report(ST_FOUND, b, byte_cnt, 1'b1);
			return 1'b1;
		end
		r = mk_report(ST_STORED, b, byte_cnt, 1'b0);
		byte_cnt++;
		return 1'b1;
	endfunction

	task automatic check_field(input string what, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
		end
	endtask

	// sample all channels at the rising edge
	always @(posedge clk) begin : monitor
		scan_report_t want, fresh;
		if (cfg_valid && cfg_ready) begin
			case (reg_idx_t'(cfg_index))
				REG_TOKEN_BYTES:   tok_bytes  = cfg_data;
				REG_TOKEN_LENGTH:  tok_len    = cfg_data[LEN_W-1:0];
				REG_OUT_CAPACITY:  buf_cap    = cfg_data[POS_W-1:0];
				REG_TIMEOUT_TICKS: tick_limit = cfg_data[TICK_W-1:0];
				default: ;
			endcase
		end
		if (out_valid && out_ready) begin
			if (scan_reports.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, got status %0d pos %0d",
					$time, status, position);
			end else begin
				want = scan_reports.pop_front();
				check_field("status", want.st, status);
				check_field("stored_byte", want.b, stored_byte);
				check_field("position", want.pos, position);
				check_field("finished", want.fin, finished);
			end
		end
		if (in_valid && in_ready) begin
			if (scan_step(cmd_t'(command), data_byte, fresh))
				scan_reports.push_back(fresh);
		end
		in_taken  <= in_valid && in_ready;
		out_taken <= out_valid && out_ready;
	end

	always @(negedge clk) begin : driver
		link_item_t nxt;
		if (!in_valid || in_taken) begin
			if (tx_wait > 0) begin
				tx_wait--;
				in_valid <= 1'b0;
			end else if (stim.size() > 0) begin
				nxt = stim.pop_front();
				command   <= nxt.cmd;
				data_byte <= nxt.b;
				in_valid  <= 1'b1;
				tx_wait   = draw_wait(tx_pace);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin : receiver
		if (out_taken) rx_wait = draw_wait(rx_pace);
		if (rx_hold) begin
			out_ready <= 1'b0;
		end else if (rx_wait > 0) begin
			rx_wait--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: no progress after %0d cycles", $time, cycle_count);
			$display("FAILED: results differ");
			$finish;
		end
	end

	task automatic offer(input cmd_t cmd, input logic [7:0] b);
		link_item_t it;
		it.cmd = cmd;
		it.b   = b;
		stim.push_back(it);
		items_offered++;
	endtask

	task automatic cfg_write(input reg_idx_t idx, input logic [63:0] value);
		@(negedge clk);
		cfg_index <= idx;
		cfg_data  <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		@(negedge clk) cfg_valid <= 1'b0;
	endtask

	task automatic program_matcher(input logic [63:0] t, input logic [3:0] len,
		input logic [15:0] cap, input logic [31:0] tmo);
		cfg_write(REG_TOKEN_BYTES, t);
		cfg_write(REG_TOKEN_LENGTH, {60'd0, len});
		cfg_write(REG_OUT_CAPACITY, {48'd0, cap});
		cfg_write(REG_TIMEOUT_TICKS, {32'd0, tmo});
	endtask

	// block idle: nothing queued, nothing offered, nothing owed, pipeline flushed
	task automatic settle();
		while (stim.size() != 0 || in_valid || scan_reports.size() != 0)
			@(posedge clk);
		repeat (PIPE_SLACK) @(posedge clk);
	endtask

	// a start followed by bytes and ticks, leaning on token bytes so partial
	// and full matches show up often
	task automatic queue_search();
		int n, pick;
		logic [3:0] len;
		len = active_len();
		if ($urandom_range(0, 9) != 0) offer(CMD_START, 8'($urandom));
		n = $urandom_range(0, 40);
		for (int k = 0; k < n; k++) begin
			pick = $urandom_range(0, 99);
			if (pick < 10) begin
				for (int i = 0; i < len; i++) offer(CMD_BYTE, tok_byte(i));
			end else if (pick < 45) begin
				offer(CMD_BYTE, tok_byte($urandom_range(0, len - 1)));
			end else if (pick < 75) begin
				offer(CMD_BYTE, 8'($urandom));
			end else if (pick < 93) begin
				offer(CMD_TICK, 8'($urandom));
			end else if (pick < 97) begin
				offer(CMD_NONE, 8'($urandom));
			end else begin
				offer(CMD_START, 8'($urandom));
			end
		end
	endtask

	initial begin
		logic [63:0] t;
		logic [3:0]  len_v;
		logic [15:0] cap_v;
		logic [31:0] tmo_v;
		int          phase_end;

		repeat (5) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// reset defaults, CR LF terminator: idle items ignored, partial match
		// restart on a repeated CR, a no-op command mid-search, item after end
		offer(CMD_BYTE, 8'h41);
		offer(CMD_TICK, 8'h00);
		offer(CMD_NONE, 8'hFF);
		offer(CMD_START, 8'h00);
		offer(CMD_BYTE, 8'h00);
		offer(CMD_BYTE, 8'h0D);
		offer(CMD_BYTE, 8'h0D);
		offer(CMD_NONE, 8'h0A);
		offer(CMD_TICK, 8'h55);
		offer(CMD_BYTE, 8'h0A);
		offer(CMD_BYTE, 8'hFF);
		settle();

		// zero timeout ends the search at start
		program_matcher(64'h0, 4'd0, 16'd1, 32'd0);
		offer(CMD_START, 8'h00);
		offer(CMD_BYTE, 8'h00);
		settle();

		// one-byte buffer: overflow beats a matching byte; then a tick timeout
		cfg_write(REG_TIMEOUT_TICKS, 64'd2);
		offer(CMD_START, 8'h00);
		offer(CMD_BYTE, 8'hFF);
		offer(CMD_BYTE, 8'h00);
		offer(CMD_START, 8'h00);
		offer(CMD_TICK, 8'h00);
		offer(CMD_TICK, 8'h00);
		settle();

		// oversize length clamps to eight bytes
		program_matcher(64'hFFEE_DDCC_BBAA_9988, 4'hF, 16'hFFFF, 32'hFFFF_FFFF);
		offer(CMD_START, 8'h00);
		for (int i = 0; i < 8; i++) offer(CMD_BYTE, tok_byte(i));
		settle();

		// long receiver stall with the sender running flat out
		program_matcher({$urandom, $urandom}, 4'd8, 16'hFFFF, 32'hFFFF_FFFF);
		tx_pace = 0;
		rx_pace = 0;
		fork
			begin
				@(posedge clk);
				rx_hold = 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				rx_hold = 1'b0;
			end
		join_none
		offer(CMD_START, 8'h00);
		repeat (150) offer(CMD_BYTE, 8'($urandom));
		settle();

		while (items_offered < ITEM_GOAL) begin
			for (int i = 0; i < 8; i++) begin
				case ($urandom_range(0, 4))
					0:       t[8*i +: 8] = 8'h0D;
					1:       t[8*i +: 8] = 8'h0A;
					2:       t[8*i +: 8] = 8'h00;
					3:       t[8*i +: 8] = 8'hFF;
					default: t[8*i +: 8] = 8'($urandom);
				endcase
			end
			if ($urandom_range(0, 3) == 0) t = {$urandom, $urandom};
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: len_v = 4'($urandom_range(1, 4));
				6, 7:             len_v = 4'($urandom_range(5, 8));
				8:                len_v = 4'd0;
				default:          len_v = 4'($urandom_range(9, 15));
			endcase
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: cap_v = 16'($urandom_range(1, 24));
				6, 7:             cap_v = 16'($urandom_range(25, 200));
				8:                cap_v = 16'hFFFF;
				default:          cap_v = 16'($urandom_range(0, 2));
			endcase
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4: tmo_v = 32'($urandom_range(1, 40));
				5, 6:          tmo_v = 32'd0;
				7:             tmo_v = 32'hFFFF_FFFF;
				default:       tmo_v = 32'($urandom_range(100, 2000));
			endcase
			program_matcher(t, len_v, cap_v, tmo_v);
			tx_pace = $urandom_range(0, 2);
			rx_pace = $urandom_range(0, 2);
			phase_end = items_offered + $urandom_range(60, 140);
			while (items_offered < phase_end) queue_search();
			settle();
		end

		if (errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
